FILE: hdl/borb_pkg.sv
package borb_pkg;

  // event codes
  localparam logic [2:0] REQ_CLEAR     = 3'd0;
  localparam logic [2:0] REQ_BUS_OFF   = 3'd1;
  localparam logic [2:0] REQ_RECOVERED = 3'd2;
  localparam logic [2:0] REQ_POLL      = 3'd3;
  localparam logic [2:0] REQ_RETRY     = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_STABLE_WINDOW = 2'd0;
  localparam logic [1:0] CFG_FIRST_BACKOFF = 2'd1;
  localparam logic [1:0] CFG_MAX_BACKOFF   = 2'd2;

  localparam logic [30:0] STABLE_WINDOW_RST = 31'd1000;
  localparam logic [31:0] FIRST_BACKOFF_RST = 32'd100;
  localparam logic [31:0] MAX_BACKOFF_RST   = 32'd5000;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] now_time;
    logic [31:0] retry_delay;
  } req_t;

  typedef struct packed {
    logic [30:0] stable_window_ms;
    logic [31:0] first_backoff_ms;
    logic [31:0] max_backoff_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] backoff_now;
    logic        restart_now;
    logic        restart_armed;
  } res_t;

endpackage

FILE: hdl/bus_off_restart_backoff.sv
// Bus-off restart policy with exponential backoff.
// A request is registered in the input stage, then its result in the result register (out_tvalid high).
// Throughput: one request per cycle unless out_tready stalls; state is updated in the same cycle the result
// register loads, so back-to-back events see each other's effects.
// Reset (rst_n low, synchronous): all state cleared, config back to 1000/100/5000 ms.
module bus_off_restart_backoff
  import borb_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] now_time, [63:32] retry_delay
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] backoff_now, [32] restart_now,
                                  // [33] restart_armed, [39:34] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg;
  req_t in_req;
  req_t s_req;
  logic s_valid;
  logic advance;
  res_t res;

  assign in_req.req_type    = in_tuser;
  assign in_req.now_time    = in_tdata[31:0];
  assign in_req.retry_delay = in_tdata[63:32];

  borb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  borb_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_req   (in_req),
    .advance  (advance),
    .s_valid  (s_valid),
    .s_req    (s_req)
  );

  borb_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s_valid   (s_valid),
    .s_req     (s_req),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {6'd0, res.restart_armed, res.restart_now, res.backoff_now};

endmodule

FILE: hdl/borb_cfg_regs.sv
module borb_cfg_regs
  import borb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stable_window_ms <= STABLE_WINDOW_RST;
      cfg_r.first_backoff_ms <= FIRST_BACKOFF_RST;
      cfg_r.max_backoff_ms   <= MAX_BACKOFF_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STABLE_WINDOW: cfg_r.stable_window_ms <= cfg_data[30:0];
        CFG_FIRST_BACKOFF: cfg_r.first_backoff_ms <= cfg_data;
        CFG_MAX_BACKOFF:   cfg_r.max_backoff_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/borb_in_stage.sv
module borb_in_stage
  import borb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  input  logic advance,
  output logic s_valid,
  output req_t s_req
);

  logic s_valid_r;
  req_t s_req_r;

  assign in_ready = !s_valid_r || advance;
  assign s_valid  = s_valid_r;
  assign s_req    = s_req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ready) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_req_r <= in_req;
    end
  end

endmodule

FILE: hdl/borb_core.sv
module borb_core
  import borb_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic s_valid,
  input  req_t s_req,
  output logic advance,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic                 out_valid_r;
  res_t                 res_r;
  res_t                 res_nxt;
  logic [31:0]          cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0] last_r, last_nxt;
  logic [31:0]          bo_r, bo_nxt;
  logic                 pend_r, pend_nxt;
  logic [TIME_BITS-1:0] dl_r, dl_nxt;

  logic                 upd;
  logic [63:0]          now_ext, win_ext, bo_ext, dly_ext;
  logic [TIME_BITS-1:0] now_t, win_t, bo_t, dly_t;
  logic [TIME_BITS-1:0] rapid_diff, poll_diff;
  logic                 rapid;
  logic                 due;
  logic [32:0]          dbl;
  logic                 fire;

  assign advance   = !out_valid_r || out_ready;
  assign upd       = s_valid && advance;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // time values live modulo 2^TIME_BITS
  assign now_ext = {32'd0, s_req.now_time};
  assign win_ext = {33'd0, cfg.stable_window_ms};
  assign bo_ext  = {32'd0, bo_r};
  assign dly_ext = {32'd0, s_req.retry_delay};
  assign now_t   = now_ext[TIME_BITS-1:0];
  assign win_t   = win_ext[TIME_BITS-1:0];
  assign bo_t    = bo_ext[TIME_BITS-1:0];
  assign dly_t   = dly_ext[TIME_BITS-1:0];

  // wrap-safe compare: not reached when the difference is negative
  assign rapid_diff = now_t - (last_r + win_t);
  assign rapid      = (cnt_r != 32'd0) && rapid_diff[TIME_BITS-1];
  assign poll_diff  = now_t - dl_r;
  assign due        = !poll_diff[TIME_BITS-1];
  assign dbl        = {bo_r, 1'b0};

  always_comb begin
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    bo_nxt   = bo_r;
    pend_nxt = pend_r;
    dl_nxt   = dl_r;
    fire     = 1'b0;
    case (s_req.req_type)
      REQ_CLEAR: begin
        cnt_nxt  = '0;
        last_nxt = '0;
        bo_nxt   = '0;
        pend_nxt = 1'b0;
        dl_nxt   = '0;
      end
      REQ_BUS_OFF: begin
        if (!rapid) begin
          bo_nxt = '0;
        end else if (bo_r == 32'd0) begin
          bo_nxt = cfg.first_backoff_ms;
        end else if (bo_r < cfg.max_backoff_ms) begin
          bo_nxt = (dbl < {1'b0, cfg.max_backoff_ms}) ? dbl[31:0] : cfg.max_backoff_ms;
        end
        if (cnt_r != 32'hFFFF_FFFF) begin
          cnt_nxt = cnt_r + 32'd1;
        end
        last_nxt = now_t;
        pend_nxt = 1'b0;
      end
      REQ_RECOVERED: begin
        if (cnt_r != 32'd0) begin
          pend_nxt = 1'b1;
          dl_nxt   = now_t + bo_t;
        end
      end
      REQ_POLL: begin
        if (pend_r && due) begin
          pend_nxt = 1'b0;
          fire     = 1'b1;
        end
      end
      REQ_RETRY: begin
        pend_nxt = 1'b1;
        dl_nxt   = now_t + dly_t;
      end
      default: ;
    endcase
    res_nxt.backoff_now   = bo_nxt;
    res_nxt.restart_now   = fire;
    res_nxt.restart_armed = pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      last_r      <= '0;
      bo_r        <= '0;
      pend_r      <= 1'b0;
      dl_r        <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= s_valid;
      end
      if (upd) begin
        cnt_r  <= cnt_nxt;
        last_r <= last_nxt;
        bo_r   <= bo_nxt;
        pend_r <= pend_nxt;
        dl_r   <= dl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      res_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fire_only_on_armed_poll: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && fire) |-> (s_req.req_type == REQ_POLL && pend_r))
    else $error("restart fired without an armed poll");

  a_bus_off_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && s_req.req_type == REQ_BUS_OFF) |=> (!pend_r && cnt_r != 32'd0))
    else $error("bus-off left a restart armed or count zero");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && s_req.req_type == REQ_CLEAR) |=> (cnt_r == 32'd0 && !pend_r && bo_r == 32'd0))
    else $error("clear did not empty the state");

  a_fire_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.restart_now && res_r.restart_armed))
    else $error("result both fired and still armed");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> ($stable(cnt_r) && $stable(bo_r) && $stable(pend_r)))
    else $error("state changed without a request");
`endif

endmodule
